[rtl/core/ptd_pkg.sv]
package ptd_pkg;

  localparam int DefTableDepth = 4096;
  localparam int DefValueWidth = 16;

  localparam int LimitWidth = 13;
  localparam logic [LimitWidth-1:0] LimitReset = 13'd4096;

  localparam int FirstPrime     = 2;
  localparam int FirstCandidate = 3;

endpackage

[rtl/core/ptd_cell.sv]
module ptd_cell #(
  parameter int VALUE_WIDTH = ptd_pkg::DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [VALUE_WIDTH-1:0] rem_i,
  input  logic [VALUE_WIDTH-1:0] dvd_i,
  input  logic [VALUE_WIDTH-1:0] dvs_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] rem_o,
  output logic [VALUE_WIDTH-1:0] dvd_o,
  output logic [VALUE_WIDTH-1:0] dvs_o
);

  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] rem_d;
  logic                   valid_q;
  logic [VALUE_WIDTH-1:0] rem_q, dvd_q, dvs_q;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_i, dvd_i[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign fits  = trial >= {1'b0, dvs_i};
  assign rem_d = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= {dvd_i[VALUE_WIDTH-2:0], 1'b0};
    dvs_q <= dvs_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dvd_o   = dvd_q;
  assign dvs_o   = dvs_q;

endmodule

[rtl/core/ptd_chain.sv]
module ptd_chain #(
  parameter int VALUE_WIDTH = ptd_pkg::DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  logic                   valid_w [VALUE_WIDTH+1];
  logic [VALUE_WIDTH-1:0] rem_w   [VALUE_WIDTH+1];
  logic [VALUE_WIDTH-1:0] dvd_w   [VALUE_WIDTH+1];
  logic [VALUE_WIDTH-1:0] dvs_w   [VALUE_WIDTH+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = '0;
  assign dvd_w[0]   = dividend_i;
  assign dvs_w[0]   = divisor_i;

  // one cell per dividend bit, msb first
  for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_cell
    ptd_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[k]),
      .rem_i  (rem_w[k]),
      .dvd_i  (dvd_w[k]),
      .dvs_i  (dvs_w[k]),
      .valid_o(valid_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .dvd_o  (dvd_w[k+1]),
      .dvs_o  (dvs_w[k+1])
    );
  end

  assign valid_o = valid_w[VALUE_WIDTH];
  assign rem_o   = rem_w[VALUE_WIDTH];

endmodule

[rtl/core/prime_generator_trial_division_unit.sv]
// done and the first prime 2 go to the result registers, then to the output registers
// a search steps per candidate through read, square and check for each stored prime p
// with p*p <= candidate and for the first one past that bound when there is one, then
// drains the divider chain and hands the result to the output; one item at a time
// reset: count 0, next candidate 3, limit 4096; the prime table is not cleared
module prime_generator_trial_division_unit #(
  parameter int TABLE_DEPTH = ptd_pkg::DefTableDepth,
  parameter int VALUE_WIDTH = ptd_pkg::DefValueWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptd_pkg::LimitWidth-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [VALUE_WIDTH-1:0]         prime_value_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] prime_index_o,
  output logic                           done_res_o
);

  import ptd_pkg::*;

  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int LimW  = (LimitWidth > CntW) ? LimitWidth : CntW;
  localparam int CandW = VALUE_WIDTH + 1;
  localparam int SqW   = 2 * VALUE_WIDTH;
  localparam int DrW   = $clog2(VALUE_WIDTH + 1);
  localparam logic [CandW-1:0] ValueMax  = {1'b0, {VALUE_WIDTH{1'b1}}};
  localparam logic [DrW-1:0]   DrainInit = DrW'(VALUE_WIDTH);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SRead   = 6'b000010,
    SSquare = 6'b000100,
    SCheck  = 6'b001000,
    SDrain  = 6'b010000,
    SOut    = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [LimitWidth-1:0]  limit_q;
  logic [CntW-1:0]        count_q, count_d, cnt_base;
  logic [CandW-1:0]       next_cand_q, next_cand_d;
  logic [CandW-1:0]       cand_q, cand_d;
  logic [CntW-1:0]        i_q, i_d, i_inc;
  logic                   comp_q, comp_d;
  logic [DrW-1:0]         drain_q, drain_d;
  logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;
  logic                   res_done_q, res_done_d;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic [IdxW-1:0]        out_idx_q;
  logic                   out_done_q;
  logic                   out_load;

  logic [LimW-1:0]        lim_ext, eff_lim;
  logic                   accept;
  logic                   issue;
  logic                   chain_valid, chain_hit;
  logic [VALUE_WIDTH-1:0] chain_rem;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] rd_q, p_q;
  logic [SqW-1:0]         sq_q;

  assign lim_ext    = LimW'(limit_q);
  assign eff_lim    = (lim_ext > LimW'(TABLE_DEPTH)) ? LimW'(TABLE_DEPTH) : lim_ext;
  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign chain_hit  = chain_valid && (chain_rem == '0);
  assign out_load   = (state_q == SOut) && (!out_valid_q || out_ready_i);
  assign cnt_base   = restart_i ? '0 : count_q;
  assign i_inc      = i_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_cand_d = next_cand_q;
    cand_d      = cand_q;
    i_d         = i_q;
    comp_d      = comp_q | chain_hit;
    drain_d     = drain_q;
    res_value_d = res_value_q;
    res_idx_d   = res_idx_q;
    res_done_d  = res_done_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IdxW-1:0];
    mem_wdata   = cand_q[VALUE_WIDTH-1:0];
    issue       = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (restart_i) begin
            count_d     = '0;
            next_cand_d = CandW'(FirstCandidate);
          end
          res_value_d = '0;
          res_idx_d   = '0;
          res_done_d  = 1'b1;
          if (LimW'(cnt_base) >= eff_lim) begin
            state_d = SOut;
          end else if (cnt_base == '0) begin
            mem_we      = 1'b1;
            mem_waddr   = '0;
            mem_wdata   = VALUE_WIDTH'(FirstPrime);
            count_d     = CntW'(1);
            res_value_d = VALUE_WIDTH'(FirstPrime);
            res_done_d  = 1'b0;
            state_d     = SOut;
          end else if (next_cand_q > ValueMax) begin
            state_d = SOut;
          end else begin
            cand_d  = next_cand_q;
            i_d     = '0;
            comp_d  = 1'b0;
            state_d = SRead;
          end
        end
      end
      SRead: begin
        state_d = SSquare;
      end
      SSquare: begin
        state_d = SCheck;
      end
      SCheck: begin
        if (SqW'(cand_q) >= sq_q) begin
          issue = 1'b1;
          i_d   = i_inc;
          if (i_inc < count_q) begin
            state_d = SRead;
          end else begin
            drain_d = DrainInit;
            state_d = SDrain;
          end
        end else begin
          drain_d = DrainInit;
          state_d = SDrain;
        end
      end
      SDrain: begin
        if (drain_q != '0) begin
          drain_d = drain_q - DrW'(1);
        end else if (comp_d) begin
          if (cand_q == ValueMax) begin
            // no prime left in range: report done, keep the state
            res_value_d = '0;
            res_idx_d   = '0;
            res_done_d  = 1'b1;
            state_d     = SOut;
          end else begin
            cand_d  = cand_q + CandW'(1);
            i_d     = '0;
            comp_d  = 1'b0;
            state_d = SRead;
          end
        end else begin
          mem_we      = 1'b1;
          count_d     = count_q + CntW'(1);
          next_cand_d = cand_q + CandW'(1);
          res_value_d = cand_q[VALUE_WIDTH-1:0];
          res_idx_d   = count_q[IdxW-1:0];
          res_done_d  = 1'b0;
          state_d     = SOut;
        end
      end
      SOut: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      limit_q     <= LimitReset;
      count_q     <= '0;
      next_cand_q <= CandW'(FirstCandidate);
      comp_q      <= 1'b0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_cand_q <= next_cand_d;
      comp_q      <= comp_d;
      drain_q     <= drain_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    i_q         <= i_d;
    res_value_q <= res_value_d;
    res_idx_q   <= res_idx_d;
    res_done_q  <= res_done_d;
    if (out_load) begin
      out_value_q <= res_value_q;
      out_idx_q   <= res_idx_q;
      out_done_q  <= res_done_q;
    end
    if (state_q == SSquare) begin
      p_q  <= rd_q;
      sq_q <= SqW'(rd_q) * SqW'(rd_q);
    end
  end

  // prime table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == SRead) begin
      rd_q <= mem[i_q[IdxW-1:0]];
    end
  end

  ptd_chain #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (issue),
    .dividend_i(cand_q[VALUE_WIDTH-1:0]),
    .divisor_i (p_q),
    .valid_o   (chain_valid),
    .rem_o     (chain_rem)
  );

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = out_value_q;
  assign prime_index_o = out_idx_q;
  assign done_res_o    = out_done_q;

  ap_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !chain_valid)
    else $error("divider chain busy while idle");

  ap_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == SDrain)) |-> (LimW'(count_q) < eff_lim))
    else $error("prime stored beyond limit");

  ap_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (cand_q <= ValueMax) && (i_q < count_q))
    else $error("division issued out of range");

  ap_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  import ptd_pkg::*;

  localparam int TableDepth   = ptd_pkg::DefTableDepth;
  localparam int ValueWidth   = ptd_pkg::DefValueWidth;
  localparam int IndexWidth   = $clog2(TableDepth);
  localparam int ValueMax     = (1 << ValueWidth) - 1;
  localparam int RandomItems  = 300;
  localparam int DrainCycles  = 64;
  localparam int CycleLimit   = 2000000;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [IndexWidth-1:0] index;
    logic                  done;
  } prime_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [LimitWidth-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [ValueWidth-1:0] prime_value_o;
  logic [IndexWidth-1:0] prime_index_o;
  logic                  done_res_o;

  prime_generator_trial_division_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_value_o (prime_value_o),
    .prime_index_o (prime_index_o),
    .done_res_o    (done_res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [ValueWidth-1:0] found_primes [TableDepth];
  int                    found_cnt = 0;
  int                    next_cand = FirstCandidate;
  logic [LimitWidth-1:0] limit_q = LimitReset;

  logic       request_q [$];
  prime_res_t prime_answers_q [$];

  logic req_fire = 1'b0;
  int   accepted_cnt = 0;
  int   result_cnt = 0;
  int   mismatch_cnt = 0;
  int   prime_cnt = 0;
  int   done_cnt = 0;
  int   restart_cnt = 0;
  int   setting_cnt = 0;
  int   cycle_cnt = 0;

  function automatic prime_res_t next_prime(input logic restart);
    prime_res_t res;
    int         lim;
    int         c;
    int         i;
    longint     p;
    bit         is_prime;
    res = '0;
    lim = (limit_q > TableDepth) ? TableDepth : int'(limit_q);
    if (restart) begin
      found_cnt = 0;
      next_cand = FirstCandidate;
    end
    if (found_cnt >= lim) begin
      res.done = 1'b1;
      return res;
    end
    if (found_cnt == 0) begin
      found_primes[0] = ValueWidth'(FirstPrime);
      found_cnt = 1;
      res.value = ValueWidth'(FirstPrime);
      return res;
    end
    for (c = next_cand; c <= ValueMax; c++) begin
      is_prime = 1'b1;
      for (i = 0; i < found_cnt; i++) begin
        p = longint'(found_primes[i]);
        if (p < 2 || p * p > c) break;
        if (c % p == 0) begin
          is_prime = 1'b0;
          break;
        end
      end
      if (is_prime) begin
        found_primes[found_cnt] = ValueWidth'(c);
        res.value = ValueWidth'(c);
        res.index = IndexWidth'(found_cnt);
        found_cnt++;
        next_cand = c + 1;
        return res;
      end
    end
    // no prime left in the value range
    res.done = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is %0d, expected %0d", result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    int send_pct;
    int recv_pct;
    send_pct = (accepted_cnt < 107) ? 38 : (accepted_cnt < 214) ? 57 : 0;
    recv_pct = (accepted_cnt < 107) ? 57 : (accepted_cnt < 214) ? 38 : 0;
    if (rst_ni) begin
      if (!in_valid_i || req_fire) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_valid_i <= 1'b1;
          restart_i  <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          restart_i  <= 1'($urandom_range(1));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    prime_res_t want;
    if (rst_ni) begin
      req_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        want = next_prime(restart_i);
        prime_answers_q.push_back(want);
        accepted_cnt++;
        if (restart_i) restart_cnt++;
        if (want.done) done_cnt++;
        else prime_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (prime_answers_q.size() == 0) begin
          report_mismatch("unexpected item, value", 32'(prime_value_o), 32'd0);
        end else begin
          want = prime_answers_q.pop_front();
          if (prime_value_o !== want.value)
            report_mismatch("prime_value", 32'(prime_value_o), 32'(want.value));
          if (prime_index_o !== want.index)
            report_mismatch("prime_index", 32'(prime_index_o), 32'(want.index));
          if (done_res_o !== want.done)
            report_mismatch("done_res", 32'(done_res_o), 32'(want.done));
        end
        result_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_cnt,
               prime_answers_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || prime_answers_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [LimitWidth-1:0] lim);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    limit_q = lim;
    setting_cnt++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // '1' is a restart item, '0' asks for the next prime
  task automatic queue_requests(input string pat);
    for (int i = 0; i < pat.len(); i++) request_q.push_back(pat[i] == "1");
  endtask

  initial begin
    int                    random_cnt;
    int                    n;
    int                    restart_pct;
    logic [LimitWidth-1:0] lim;
    random_cnt = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limit: 2 3 5, restart gives 2, then 3
    queue_requests("00010");
    // zero limit answers done even on restart, but the restart still clears
    set_limit(0);
    queue_requests("01");
    set_limit(3);
    queue_requests("00001");
    set_limit(1);
    queue_requests("010");
    // limit above the table depth
    set_limit({LimitWidth{1'b1}});
    queue_requests("0010");
    set_limit(LimitReset);
    queue_requests("0");

    while (random_cnt < RandomItems) begin
      case ($urandom_range(9))
        0: lim = 0;
        1: lim = LimitReset;
        2: lim = LimitWidth'($urandom_range({LimitWidth{1'b1}}, TableDepth + 1));
        3: lim = 1;
        default: lim = LimitWidth'($urandom_range(120, 2));
      endcase
      set_limit(lim);
      n = $urandom_range(40, 15);
      // mostly long runs of next-prime items, sometimes restart-heavy noise
      restart_pct = ($urandom_range(3) == 0) ? 40 : 6;
      for (int k = 0; k < n; k++) request_q.push_back($urandom_range(99) < restart_pct);
      random_cnt += n;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests (%0d restarts) over %0d limit settings", accepted_cnt,
             restart_cnt, setting_cnt);
    $display("%0d primes and %0d done answers checked, %0d mismatches", prime_cnt,
             done_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
